// ===== rtl/core/bsa_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitmap slot allocator package
// Request and response beat types, request codes and word geometry that the
// allocator, its word unit and its checker share.
// ----------------------------------------------------------------------------
package bsa_pkg;

	localparam int WORD_W  = 32;
	localparam int WBIT_W  = 5;
	localparam int REQ_W   = 3;
	localparam int INDEX_W = 10;
	localparam int LIMIT_W = 11;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

	localparam logic [REQ_W-1:0] REQ_TOGGLE = 3'd0;
	localparam logic [REQ_W-1:0] REQ_GET    = 3'd1;
	localparam logic [REQ_W-1:0] REQ_FLAG   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_UNFLAG = 3'd3;
	localparam logic [REQ_W-1:0] REQ_FIND   = 3'd4;

	typedef struct packed {
		logic [REQ_W-1:0]   req_type;
		logic [INDEX_W-1:0] bit_index;
	} req_t;

	typedef struct packed {
		logic               bit_value;
		logic               success;
		logic [INDEX_W-1:0] free_index;
	} rsp_t;

	// Result of one pass of the shared word unit.
	typedef struct packed {
		logic              bit_val;
		logic              ok;
		logic              write;
		logic [WORD_W-1:0] new_word;
		logic              found;
		logic [WBIT_W-1:0] pos;
	} wu_res_t;

endpackage

// ===== rtl/core/bsa_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module bsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/bsa_word_unit.sv =====
// ----------------------------------------------------------------------------
// Allocator word unit
// Works on one 32-bit bitmap word: the single-bit operations and the search
// for the lowest free bit inside a mask of searchable bits.
// ----------------------------------------------------------------------------
module bsa_word_unit (
	input  logic [bsa_pkg::WORD_W-1:0] word,
	input  logic [bsa_pkg::WBIT_W-1:0] bit_sel,
	input  logic [bsa_pkg::REQ_W-1:0]  op,
	input  logic [bsa_pkg::WORD_W-1:0] mask,
	output bsa_pkg::wu_res_t           res
);
	import bsa_pkg::*;

	logic [WORD_W-1:0] sel_onehot;
	logic [WORD_W-1:0] free_bits;
	logic [WORD_W-1:0] lowest;
	logic              bv;

	assign sel_onehot = WORD_W'(1) << bit_sel;
	assign bv         = word[bit_sel];
	assign free_bits  = ~word & mask;
	// Isolate the lowest set bit; the encoder below then needs no priority.
	assign lowest     = free_bits & (~free_bits + WORD_W'(1));

	always_comb begin
		res          = '0;
		res.bit_val  = bv;
		res.new_word = word ^ sel_onehot;
		res.found    = |free_bits;
		for (int k = 0; k < WBIT_W; k++) begin
			for (int i = 0; i < WORD_W; i++) begin
				if (((i >> k) & 1) == 1) begin
					res.pos[k] = res.pos[k] | lowest[i];
				end
			end
		end
		case (op)
			REQ_TOGGLE: begin
				res.ok    = 1'b1;
				res.write = 1'b1;
			end
			REQ_GET: begin
				res.ok = 1'b1;
			end
			REQ_FLAG: begin
				res.ok    = ~bv;
				res.write = ~bv;
			end
			REQ_UNFLAG: begin
				res.ok    = bv;
				res.write = bv;
			end
			default: begin
				res.ok    = 1'b0;
				res.write = 1'b0;
			end
		endcase
	end

endmodule

// ===== rtl/core/bitmap_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// Bitmap slot allocator
// Occupancy bitmap with toggle, get, test-and-set, test-and-clear and
// find-first-free requests, served by a sequencer around one word unit.
// ----------------------------------------------------------------------------
// Usage. A request beat on in_data (req_type, bit_index) is taken when
// in_valid is high and in_stall is low; exactly one response beat follows on
// out_data (bit_value, success, free_index), taken when out_valid is high and
// out_stall is low. The block serves one request at a time: in_stall stays
// high from the accepting edge until the request has been handed to the
// output register.
// The bitmap lives in a RAM of 32-bit words. Toggle, get, flag and unflag
// read the word, update it through the word unit and write it back when it
// changes; the response passes from the read and modify states through the
// done state to the output register. Find free streams the words below the
// search limit through the same unit, one word per cycle, and stops early
// when a free slot turns up. After reset the sequencer sweeps the RAM,
// clearing one word per cycle over all NUM_SLOTS / 32 words (rounded up);
// requests are held off meanwhile.
// The search_limit register resets to 1024 and is written through cfg_we and
// cfg_wdata. A stalled receiver simply leaves the response in the output
// register, and a finished request waits for that register to empty.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator #(
	parameter int NUM_SLOTS = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  bsa_pkg::req_t               in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output bsa_pkg::rsp_t               out_data,
	input  logic                        cfg_we,
	input  logic [bsa_pkg::LIMIT_W-1:0] cfg_wdata
);
	import bsa_pkg::*;

	localparam int WORDS = (NUM_SLOTS + WORD_W - 1) / WORD_W;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int CW    = $clog2(WORDS + 1);
	localparam int SW    = ($clog2(NUM_SLOTS + 1) > LIMIT_W) ? $clog2(NUM_SLOTS + 1) : LIMIT_W;
	localparam int SLW   = AW + WBIT_W;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BREAD,
		ST_BMOD,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic [REQ_W-1:0]    op_q;
	logic [INDEX_W-1:0]  idx_q;
	logic [CW-1:0]       clr_q;
	logic [CW-1:0]       iw_q;
	logic [CW-1:0]       cw_q;
	logic                chk_q;
	logic [CW-1:0]       last_q;
	logic [WBIT_W-1:0]   rem_q;
	logic [LIMIT_W-1:0]  search_limit_q;
	rsp_t                res_q;
	logic                out_valid_q;
	rsp_t                out_q;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [WORD_W-1:0]   ram_wdata;
	logic                ram_re;
	logic [AW-1:0]       ram_raddr;
	logic [WORD_W-1:0]   ram_rdata;

	logic [31:0]         idx_ext;
	logic [31:0]         in_idx_ext;
	logic [AW-1:0]       idx_word;
	logic                in_idx_ok;
	logic [SW:0]         lim;
	logic [SW:0]         nwords_m1;
	logic [WORD_W-1:0]   scan_mask;
	logic [SLW-1:0]      slot_full;
	logic [31:0]         slot_ext;
	logic                out_free;
	wu_res_t             wu;

	// Word address of the stored request's slot.
	assign idx_ext    = 32'(idx_q);
	assign idx_word   = idx_ext[AW+WBIT_W-1:WBIT_W];
	assign in_idx_ext = 32'(in_data.bit_index);
	assign in_idx_ok  = in_idx_ext < 32'(NUM_SLOTS);

	// Effective search limit, saturated to the bitmap size, and the index of
	// the last word that the scan has to look at.
	always_comb begin
		lim = (SW + 1)'(search_limit_q);
		if (lim > (SW + 1)'(NUM_SLOTS)) begin
			lim = (SW + 1)'(NUM_SLOTS);
		end
		nwords_m1 = ((lim + (SW + 1)'(WORD_W - 1)) >> WBIT_W) - (SW + 1)'(1);
	end

	// Only the last word of the scan may be cut short by the limit.
	assign scan_mask = (cw_q == last_q && rem_q != '0) ?
		((WORD_W'(1) << rem_q) - WORD_W'(1)) : '1;

	assign slot_full = {cw_q[AW-1:0], wu.pos};
	assign slot_ext  = 32'(slot_full);

	assign ram_we    = (state_q == ST_CLEAR) || (state_q == ST_BMOD && wu.write);
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_q[AW-1:0] : idx_word;
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : wu.new_word;
	assign ram_re    = (state_q == ST_BREAD) || (state_q == ST_SCAN && iw_q <= last_q);
	assign ram_raddr = (state_q == ST_BREAD) ? idx_word : iw_q[AW-1:0];

	assign out_free  = ~out_valid_q | ~out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	bsa_ram #(
		.WIDTH (WORD_W),
		.DEPTH (WORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// The same unit serves the single-bit operations and the scan.
	bsa_word_unit u_unit (
		.word    (ram_rdata),
		.bit_sel (idx_q[WBIT_W-1:0]),
		.op      (op_q),
		.mask    (scan_mask),
		.res     (wu)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			op_q           <= '0;
			idx_q          <= '0;
			clr_q          <= '0;
			iw_q           <= '0;
			cw_q           <= '0;
			chk_q          <= 1'b0;
			last_q         <= '0;
			rem_q          <= '0;
			search_limit_q <= LIMIT_RESET;
			res_q          <= '0;
			out_valid_q    <= 1'b0;
			out_q          <= '0;
		end else begin
			if (cfg_we) begin
				search_limit_q <= cfg_wdata;
			end

			// A finished request refills the output register; otherwise a
			// taken beat empties it.
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + CW'(1);
					if (clr_q == CW'(WORDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						op_q  <= in_data.req_type;
						idx_q <= in_data.bit_index;
						res_q <= '0;
						if (in_data.req_type == REQ_FIND) begin
							iw_q   <= '0;
							cw_q   <= '0;
							chk_q  <= 1'b0;
							last_q <= nwords_m1[CW-1:0];
							rem_q  <= lim[WBIT_W-1:0];
							// An empty search range finds nothing.
							state_q <= (lim == '0) ? ST_DONE : ST_SCAN;
						end else if (in_data.req_type <= REQ_UNFLAG && in_idx_ok) begin
							state_q <= ST_BREAD;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_BREAD: begin
					state_q <= ST_BMOD;
				end
				ST_BMOD: begin
					res_q.bit_value  <= wu.bit_val;
					res_q.success    <= wu.ok;
					res_q.free_index <= '0;
					state_q          <= ST_DONE;
				end
				ST_SCAN: begin
					if (ram_re) begin
						iw_q <= iw_q + CW'(1);
					end
					chk_q <= ram_re;
					if (chk_q) begin
						if (wu.found) begin
							res_q.bit_value  <= 1'b0;
							res_q.success    <= 1'b1;
							res_q.free_index <= slot_ext[INDEX_W-1:0];
							state_q          <= ST_DONE;
						end else if (cw_q == last_q) begin
							res_q   <= '0;
							state_q <= ST_DONE;
						end else begin
							cw_q <= cw_q + CW'(1);
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_q   <= res_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/bsa_checker.sv =====
// ----------------------------------------------------------------------------
// Bitmap slot allocator checker
// Port-level assertions on the allocator, attached by a bind statement.
// ----------------------------------------------------------------------------
module bsa_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_stall,
	input logic          out_valid,
	input logic          out_stall,
	input bsa_pkg::rsp_t out_data
);
	import bsa_pkg::*;

	logic [1:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid & ~in_stall;
	assign out_acc = out_valid & ~out_stall;

	// Requests taken whose response beat has not yet been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("response beat changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("second request taken while one is in service");

	a_no_spurious_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("response beat without a pending request");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two requests outstanding");

	a_fail_zero_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.success |-> out_data.free_index == '0)
		else $error("failed response carries a slot index");

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

// ===== sim/bitmap_slot_allocator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap slot allocator testbench
// Drives request beats into the allocator and checks each response beat
// against a behavioural copy of the occupancy map. A short scripted part comes
// first, then random allocate/free traffic over a range of search limits.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_test;
	import bsa_pkg::*;

	localparam int SLOTS = 1024;

	// Request codes with no defined operation. The block must leave the map
	// alone and answer with an all-zero response.
	localparam logic [REQ_W-1:0] REQ_RSVD5 = 3'd5;
	localparam logic [REQ_W-1:0] REQ_RSVD6 = 3'd6;
	localparam logic [REQ_W-1:0] REQ_RSVD7 = 3'd7;

	// A find over the whole map is the slowest request, so this covers any
	// response that is still on its way when the last expected beat has arrived.
	localparam int SETTLE = 40;
	// Cycles without any accepted beat before the run is declared hung.
	localparam int HANG_LIMIT = 5000;

	typedef enum logic {ROW_REQ, ROW_LIMIT} row_kind_t;

	// One line of the scripted part: either a request beat, with its response
	// typed in where it is obvious, or a write of the search limit.
	typedef struct {
		row_kind_t            kind;
		req_t                 req;
		bit                   typed;
		rsp_t                 want;
		logic [LIMIT_W-1:0]   limit;
	} row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	req_t               in_data;
	logic               out_valid;
	logic               out_stall;
	rsp_t               out_data;
	logic               cfg_we;
	logic [LIMIT_W-1:0] cfg_wdata;

	// Our own picture of the block: which slots are taken, and how far a find
	// is allowed to look.
	bit                 slot_taken [SLOTS];
	logic [LIMIT_W-1:0] scan_limit;

	// Responses owed by the block, oldest first.
	rsp_t               owed_replies [$];
	row_t               script [$];

	// While calm is set neither side inserts idle cycles, giving one long
	// stretch of back-to-back beats.
	bit                 calm;
	int                 fails;
	int                 quiet;

	bitmap_slot_allocator #(
		.NUM_SLOTS(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------------
	// Behavioural model of one request. It updates the map and returns the
	// response that the block owes for it.
	// ------------------------------------------------------------------------
	function automatic rsp_t apply_request(input req_t r);
		rsp_t p;
		int   span;
		int   s;
		p = '0;
		if (r.req_type == REQ_FIND) begin
			// A limit above the map size simply means the whole map.
			span = (scan_limit > SLOTS) ? SLOTS : int'(scan_limit);
			for (s = 0; s < span && !p.success; s++) begin
				if (!slot_taken[s]) begin
					p.success = 1'b1;
					p.free_index = INDEX_W'(s);
				end
			end
		end else if (r.req_type <= REQ_UNFLAG && r.bit_index < SLOTS) begin
			p.bit_value = slot_taken[r.bit_index];
			case (r.req_type)
				REQ_TOGGLE: begin
					slot_taken[r.bit_index] = !p.bit_value;
					p.success = 1'b1;
				end
				REQ_GET: begin
					p.success = 1'b1;
				end
				REQ_FLAG: begin
					// Test-and-set only claims a free slot.
					if (!p.bit_value) begin
						slot_taken[r.bit_index] = 1'b1;
						p.success = 1'b1;
					end
				end
				default: begin
					// Test-and-clear only releases a taken slot.
					if (p.bit_value) begin
						slot_taken[r.bit_index] = 1'b0;
						p.success = 1'b1;
					end
				end
			endcase
		end
		return p;
	endfunction

	function automatic req_t make_req(input logic [REQ_W-1:0] op, input int unsigned idx);
		req_t r;
		r.req_type = op;
		r.bit_index = INDEX_W'(idx);
		return r;
	endfunction

	function automatic row_t rq(input logic [REQ_W-1:0] op, input int unsigned idx);
		row_t w;
		w.kind = ROW_REQ;
		w.req = make_req(op, idx);
		w.typed = 1'b0;
		w.want = '0;
		w.limit = '0;
		return w;
	endfunction

	// A request row whose response is typed in: bit_value, success, free_index.
	function automatic row_t rqx(input logic [REQ_W-1:0] op, input int unsigned idx,
			input bit bv, input bit ok, input int unsigned fi);
		row_t w;
		w = rq(op, idx);
		w.typed = 1'b1;
		w.want.bit_value = bv;
		w.want.success = ok;
		w.want.free_index = INDEX_W'(fi);
		return w;
	endfunction

	function automatic row_t cf(input int unsigned lim);
		row_t w;
		w = rq(REQ_GET, 0);
		w.kind = ROW_LIMIT;
		w.limit = LIMIT_W'(lim);
		return w;
	endfunction

	// Mostly slots near the search window, where finds and frees interact,
	// with the odd index drawn from the whole map.
	function automatic int unsigned slot_pick(input int win);
		if ($urandom_range(7) == 0) begin
			return $urandom_range(SLOTS - 1);
		end
		return $urandom_range(win - 1);
	endfunction

	// ------------------------------------------------------------------------
	// Request side. Every task here is entered and left just after a falling
	// edge, and touches in_valid at most once per falling edge.
	// ------------------------------------------------------------------------
	task automatic issue(input req_t r, input bit typed, input rsp_t typed_rsp,
			output rsp_t p);
		while (!calm && $urandom_range(99) < 26) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		// The beat and its valid are held until the block takes them.
		do @(posedge clk); while (in_stall);
		p = apply_request(r);
		owed_replies.push_back(typed ? typed_rsp : p);
		@(negedge clk);
	endtask

	task automatic send(input req_t r, output rsp_t p);
		issue(r, 1'b0, '0, p);
	endtask

	// Holds the request side off until every owed response has come back.
	// The block serves one request at a time, so it is then idle.
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (owed_replies.size() != 0);
	endtask

	task automatic set_scan_limit(input logic [LIMIT_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		scan_limit = v;
	endtask

	// Random allocator traffic under the current search limit. An allocation
	// is the well-formed pair: find a free slot, then claim the slot found.
	task automatic mixed_phase(input int n_items);
		rsp_t                p;
		rsp_t                hit;
		int                  win;
		int                  done;
		int                  pick;
		logic [REQ_W-1:0]    op;
		win = (scan_limit == 0) ? 16 :
			((scan_limit + 4 > SLOTS) ? SLOTS : int'(scan_limit) + 4);
		done = 0;
		while (done < n_items) begin
			pick = $urandom_range(99);
			if (pick < 35) begin
				send(make_req(REQ_FIND, $urandom_range(SLOTS - 1)), hit);
				send(make_req(REQ_FLAG,
					hit.success ? int'(hit.free_index) : slot_pick(win)), p);
				done += 2;
			end else if (pick < 55) begin
				send(make_req(REQ_UNFLAG, slot_pick(win)), p);
				done++;
			end else if (pick < 65) begin
				send(make_req(REQ_TOGGLE, slot_pick(win)), p);
				done++;
			end else if (pick < 75) begin
				send(make_req(REQ_GET, slot_pick(win)), p);
				done++;
			end else if (pick < 85) begin
				send(make_req(REQ_FLAG, slot_pick(win)), p);
				done++;
			end else if (pick < 92) begin
				send(make_req(REQ_FIND, $urandom_range(SLOTS - 1)), p);
				done++;
			end else if (pick < 96) begin
				// Undefined codes are noise and do not count as traffic.
				case ($urandom_range(2))
					0: op = REQ_RSVD5;
					1: op = REQ_RSVD6;
					default: op = REQ_RSVD7;
				endcase
				send(make_req(op, $urandom_range(SLOTS - 1)), p);
			end else if (!calm) begin
				// Let the pipeline run dry before carrying on.
				drain();
			end
		end
	endtask

	// Claims every slot in a shuffled order, with the occasional find along
	// the way, so that finds see a nearly full map and high free indices.
	task automatic fill_phase();
		int unsigned order [SLOTS];
		int unsigned tmp;
		int          i;
		int          j;
		rsp_t        p;
		for (i = 0; i < SLOTS; i++) order[i] = i;
		for (i = SLOTS - 1; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (i = 0; i < SLOTS; i++) begin
			send(make_req(REQ_FLAG, order[i]), p);
			if ($urandom_range(15) == 0) begin
				send(make_req(REQ_FIND, $urandom_range(SLOTS - 1)), p);
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Response side: random stalls, and a check of every accepted beat
	// against the oldest owed response.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 26);
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (owed_replies.size() == 0) begin
				$error("response beat with nothing owed: %p", out_data);
				fails++;
			end else begin
				want = owed_replies.pop_front();
				if (out_data.bit_value !== want.bit_value) begin
					$error("bit_value: expected %0d, got %0d",
						want.bit_value, out_data.bit_value);
					fails++;
				end
				if (out_data.success !== want.success) begin
					$error("success: expected %0d, got %0d",
						want.success, out_data.success);
					fails++;
				end
				if (out_data.free_index !== want.free_index) begin
					$error("free_index: expected %0d, got %0d",
						want.free_index, out_data.free_index);
					fails++;
				end
			end
		end
	end

	// Watchdog: any accepted beat on either side counts as progress.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet = 0;
			end else if (quiet >= HANG_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end else begin
				quiet++;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus.
	// ------------------------------------------------------------------------
	initial begin
		rsp_t p;
		int   k;
		int   n;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		calm = 1'b0;
		fails = 0;
		quiet = 0;
		scan_limit = LIMIT_RESET;

		// Scripted part. Straight after reset every slot is free and finds
		// look at the whole map. The first rows walk slot 0 through get and flag
		// and slot 1023 through toggle, get and unflag; later rows check the
		// undefined codes, a zero limit, a limit of one over a taken slot, and a
		// limit that has to saturate to the map size.
		script = {
			rqx(REQ_FIND,   0,      0, 1, 0),
			rqx(REQ_GET,    0,      0, 1, 0),
			rqx(REQ_FLAG,   0,      0, 1, 0),
			rqx(REQ_FLAG,   0,      1, 0, 0),
			rqx(REQ_FIND,   10'h3FF, 0, 1, 1),
			rqx(REQ_TOGGLE, 1023,   0, 1, 0),
			rqx(REQ_GET,    1023,   1, 1, 0),
			rqx(REQ_UNFLAG, 1023,   1, 1, 0),
			rqx(REQ_UNFLAG, 1023,   0, 0, 0),
			rq(REQ_TOGGLE,  10'h2AA),
			rq(REQ_UNFLAG,  10'h2AA),
			rq(REQ_FLAG,    10'h155),
			rqx(REQ_RSVD5,  10'h3FF, 0, 0, 0),
			rqx(REQ_RSVD6,  0,      0, 0, 0),
			rqx(REQ_RSVD7,  10'h155, 0, 0, 0),
			rqx(REQ_TOGGLE, 0,      1, 1, 0),
			rqx(REQ_FIND,   0,      0, 1, 0),
			cf(0),
			rqx(REQ_FIND,   0,      0, 0, 0),
			rqx(REQ_FLAG,   0,      0, 1, 0),
			cf(1),
			rqx(REQ_FIND,   0,      0, 0, 0),
			cf(2047),
			rqx(REQ_FIND,   0,      0, 1, 1),
			cf(LIMIT_RESET),
			rq(REQ_UNFLAG,  0)
		};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// The block holds requests off during its clearing sweep; issue()
		// simply waits for the handshake.
		foreach (script[i]) begin
			if (script[i].kind == ROW_LIMIT) begin
				set_scan_limit(script[i].limit);
			end else begin
				issue(script[i].req, script[i].typed, script[i].want, p);
			end
		end

		// Random traffic over a spread of limits: around a word boundary, the
		// extremes, values past the map size and one drawn at random. The
		// phase at a limit of 32 runs without any idling on either side.
		for (k = 0; k < 10; k++) begin
			case (k)
				0: n = 1024;
				1: n = 33;
				2: n = 32;
				3: n = 0;
				4: n = 1;
				5: n = 31;
				6: n = 2047;
				7: n = 1025;
				8: n = 5;
				default: n = $urandom_range(2047);
			endcase
			set_scan_limit(LIMIT_W'(n));
			calm = (k == 2);
			mixed_phase(55);
			calm = 1'b0;
		end

		// Fill the whole map, then look for room where there is none, with
		// the limit both at the map size and past it.
		set_scan_limit(LIMIT_RESET);
		fill_phase();
		send(make_req(REQ_FIND, 0), p);
		set_scan_limit(11'd2047);
		send(make_req(REQ_FIND, 10'h3FF), p);
		send(make_req(REQ_UNFLAG, 1023), p);
		send(make_req(REQ_FIND, 0), p);
		// Free a few slots one at a time and allocate them again.
		for (k = 0; k < 8; k++) begin
			send(make_req(REQ_UNFLAG, $urandom_range(SLOTS - 1)), p);
			send(make_req(REQ_FIND, $urandom_range(SLOTS - 1)), p);
			send(make_req(REQ_FLAG, p.success ? int'(p.free_index) : 0), p);
		end

		drain();
		repeat (SETTLE) @(posedge clk);
		if (fails == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== bitmap_slot_allocator.f =====
rtl/core/bsa_pkg.sv
rtl/core/bsa_ram.sv
rtl/core/bsa_word_unit.sv
rtl/core/bitmap_slot_allocator.sv
rtl/core/bsa_checker.sv
sim/bitmap_slot_allocator_test.sv
